// File: sv/slcd_pkg.sv
package slcd_pkg;

  localparam int MAX_LEN   = 16;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_RESET  = LEN_W'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_SUM,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start_frame;  // sync seen: sum <= byte
    logic take_len;     // length accepted
    logic take_data;    // payload byte
    logic start_emit;   // good checksum: rewind read pointer
    logic next_emit;    // result item taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sync_hit;
    logic len_ok;
    logic data_done;
    logic sum_ok;
    logic emit_last;
  } status_t;

endpackage

// File: sv/slcd_ctrl.sv
module slcd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  slcd_pkg::status_t st,
  output slcd_pkg::cmd_t    cmd
);

  slcd_pkg::state_t state;
  slcd_pkg::state_t state_next;
  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slcd_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      slcd_pkg::ST_HUNT: begin
        if (in_fire && st.sync_hit) state_next = slcd_pkg::ST_LEN;
      end
      slcd_pkg::ST_LEN: begin
        if (in_fire) state_next = st.len_ok ? slcd_pkg::ST_DATA : slcd_pkg::ST_HUNT;
      end
      slcd_pkg::ST_DATA: begin
        if (in_fire && st.data_done) state_next = slcd_pkg::ST_SUM;
      end
      slcd_pkg::ST_SUM: begin
        if (in_fire) state_next = st.sum_ok ? slcd_pkg::ST_EMIT : slcd_pkg::ST_HUNT;
      end
      slcd_pkg::ST_EMIT: begin
        if (out_fire && st.emit_last) state_next = slcd_pkg::ST_HUNT;
      end
      default: state_next = slcd_pkg::ST_HUNT;
    endcase
  end

  always_comb begin
    in_ready  = (state != slcd_pkg::ST_EMIT);
    out_valid = (state == slcd_pkg::ST_EMIT);
    cmd       = '0;
    case (state)
      slcd_pkg::ST_HUNT: cmd.start_frame = in_fire && st.sync_hit;
      slcd_pkg::ST_LEN:  cmd.take_len    = in_fire && st.len_ok;
      slcd_pkg::ST_DATA: cmd.take_data   = in_fire;
      slcd_pkg::ST_SUM:  cmd.start_emit  = in_fire && st.sum_ok;
      slcd_pkg::ST_EMIT: cmd.next_emit   = out_fire;
      default: cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during readout");

  a_good_sum_starts_readout: assert property (@(posedge clk) disable iff (rst)
    (in_fire && state == slcd_pkg::ST_SUM && st.sum_ok) |=> out_valid)
    else $error("good frame not emitted");

  a_readout_continues: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !st.emit_last) |=> out_valid) else $error("readout cut short");
`endif

endmodule

// File: sv/slcd_dp.sv
module slcd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slcd_pkg::CFG_W-1:0]        cfg_data,
  input  logic [slcd_pkg::BYTE_W-1:0]       rx_byte,
  input  slcd_pkg::cmd_t                    cmd,
  output slcd_pkg::status_t                 st,
  output logic [slcd_pkg::BYTE_W-1:0]       data_byte,
  output logic [slcd_pkg::IDX_W-1:0]        byte_index,
  output logic [slcd_pkg::LEN_W-1:0]        payload_length,
  output logic                              last
);

  logic [slcd_pkg::BYTE_W-1:0] sync_value;
  logic [slcd_pkg::LEN_W-1:0]  max_payload;
  logic [slcd_pkg::BYTE_W-1:0] running_sum;
  logic [slcd_pkg::LEN_W-1:0]  byte_count;
  logic [slcd_pkg::LEN_W-1:0]  frame_length;
  logic [slcd_pkg::IDX_W-1:0]  rd_ptr;
  logic [slcd_pkg::BYTE_W-1:0] payload_store [slcd_pkg::MAX_LEN];

  logic [slcd_pkg::LEN_W-1:0]  eff_max;
  logic [slcd_pkg::LEN_W-1:0]  count_inc;
  logic [slcd_pkg::LEN_W-1:0]  rd_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value  <= slcd_pkg::SYNC_RESET;
      max_payload <= slcd_pkg::MAX_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == slcd_pkg::REG_SYNC_VALUE) begin
        sync_value <= cfg_data;
      end else if (cfg_index == slcd_pkg::REG_MAX_PAYLOAD) begin
        max_payload <= cfg_data[slcd_pkg::LEN_W-1:0];
      end
    end
  end

  assign eff_max   = (max_payload > slcd_pkg::LEN_W'(slcd_pkg::MAX_LEN))
                   ? slcd_pkg::LEN_W'(slcd_pkg::MAX_LEN) : max_payload;
  assign count_inc = byte_count + slcd_pkg::LEN_W'(1);
  assign rd_inc    = slcd_pkg::LEN_W'(rd_ptr) + slcd_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      byte_count   <= '0;
      frame_length <= '0;
      rd_ptr       <= '0;
    end else begin
      if (cmd.start_frame) begin
        running_sum <= rx_byte;
        byte_count  <= '0;
      end
      if (cmd.take_len) begin
        frame_length <= rx_byte[slcd_pkg::LEN_W-1:0];
        running_sum  <= running_sum + rx_byte;
        byte_count   <= '0;
      end
      if (cmd.take_data) begin
        running_sum <= running_sum + rx_byte;
        byte_count  <= count_inc;
      end
      if (cmd.start_emit) rd_ptr <= '0;
      if (cmd.next_emit)  rd_ptr <= rd_inc[slcd_pkg::IDX_W-1:0];
    end
  end

  // payload store: no reset, only entries of the current frame are read
  always_ff @(posedge clk) begin
    if (cmd.take_data && byte_count < slcd_pkg::LEN_W'(slcd_pkg::MAX_LEN)) begin
      payload_store[byte_count[slcd_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    st.sync_hit  = (rx_byte == sync_value);
    st.len_ok    = (rx_byte != '0) && (rx_byte <= slcd_pkg::BYTE_W'(eff_max));
    st.data_done = (count_inc >= frame_length);
    st.sum_ok    = (rx_byte == running_sum);
    st.emit_last = (rd_inc == frame_length);
  end

  assign data_byte      = payload_store[rd_ptr];
  assign byte_index     = rd_ptr;
  assign payload_length = frame_length;
  assign last           = st.emit_last;

endmodule

// File: sv/sync_length_checksum_deframer.sv
// Frame receiver: one received byte per input item. It hunts for the sync byte
// (register 0, reset 0xAA); the next byte is the payload length, which must be
// 1..max_payload (register 1, reset 16, low 5 bits kept, 17..31 act as 16) or the frame
// is dropped and the hunt resumes at the following byte. Length payload bytes
// follow, then a checksum byte that must equal the 8-bit wrapping sum of sync,
// length and payload bytes. On a match the payload is emitted as one result
// item per byte (data_byte, byte_index, payload_length, last on the final one);
// a bad frame emits nothing. After a good checksum the input stalls while the
// stored payload is read out, one item per cycle when out_ready is high.
// Readout goes through the single read port of the 16-byte payload store.
// Config writes (cfg_write_en, cfg_index, cfg_data) take effect the next
// cycle; indexes beyond 1 are ignored.
module sync_length_checksum_deframer (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write_en,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slcd_pkg::CFG_W-1:0]        cfg_data,
  // received bytes
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [slcd_pkg::BYTE_W-1:0]       rx_byte,
  // checked payload bytes
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [slcd_pkg::BYTE_W-1:0]       data_byte,
  output logic [slcd_pkg::IDX_W-1:0]        byte_index,
  output logic [slcd_pkg::LEN_W-1:0]        payload_length,
  output logic                              last
);

  slcd_pkg::cmd_t    cmd;
  slcd_pkg::status_t st;

  // sequencer: hunt / length / payload / checksum / readout
  slcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // registers, running sum, counters and payload store
  slcd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .st             (st),
    .data_byte      (data_byte),
    .byte_index     (byte_index),
    .payload_length (payload_length),
    .last           (last)
  );

endmodule
